// File: rtl/tbu_pkg.sv
// package for the telemetry bitfield unpacker
// holds sizes, command flag masks, register and function codes, the sensor table entry type and the channel item types
package tbu_pkg;
  localparam int MaxSensors   = 16;
  localparam int MaxFieldBits = 32;
  localparam int IdxW = $clog2(MaxSensors);
  localparam int CntW = $clog2(MaxSensors + 1);
  localparam int BitW = $clog2(MaxFieldBits + 1);

  localparam logic [7:0] FlagWrite = 8'b1000_0000;
  localparam logic [7:0] FlagState = 8'b0100_0000;
  localparam logic [7:0] TypeMask  = 8'b0011_1111;
  localparam logic [7:0] PosMax    = 8'd255;

  localparam logic [0:0] RegClearCode   = 1'b0;
  localparam logic [0:0] RegHeaderBytes = 1'b1;

  localparam logic [0:0] FuncCommand = 1'b0;
  localparam logic [0:0] FuncPacket  = 1'b1;

  typedef struct packed {
    logic [7:0]  pin;
    logic [5:0]  width;
    logic [31:0] scale;
  } entry_t;

  typedef struct packed {
    logic [0:0]  func;
    logic [7:0]  pin;
    logic [7:0]  command_byte;
    logic [5:0]  field_bits;
    logic [31:0] field_scale;
    logic [7:0]  packet_byte;
    logic [0:0]  last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_pin;
    logic [31:0] out_value;
    logic [0:0]  last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [3:0] idx;
    logic [31:0] data;
  } cfg_item_t;
endpackage

// File: rtl/tbu_if.sv
// valid/ready channel interfaces for the unpacker
// depends on tbu_pkg
interface tbu_in_if (input logic clk);
  import tbu_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tbu_out_if (input logic clk);
  import tbu_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tbu_cfg_if (input logic clk);
  import tbu_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/tbu_scaler.sv
// serial signed magnitude times q16.16 scale, shift-add one bit per cycle
// truncates toward zero and saturates to 32 bits; depends on tbu_pkg
module tbu_scaler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] field,
  input  logic [5:0]  width,
  input  logic [31:0] scale,
  output logic        done,
  output logic [31:0] result
);
  import tbu_pkg::*;

  logic        busy;
  logic [30:0] mag;
  logic [31:0] smag;
  logic [62:0] acc;
  logic [4:0]  cnt;
  logic        neg;
  logic [31:0] mask;
  logic [31:0] sabs;
  logic [46:0] prod;
  logic [32:0] sum;

  always_comb begin
    mask = (width > 6'd1) ? ((32'h1 << (width - 6'd1)) - 32'h1) : 32'h0;
    sabs = scale[31] ? (32'h0 - scale) : scale;
    prod = acc[62:16];
    sum = {1'b0, acc[62:31]} + (mag[0] ? {1'b0, smag} : 33'd0);
  end

  // add at the top, shift right one place per magnitude bit
  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (cnt == 5'd30);
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      mag  <= 31'((field >> 1) & mask);
      smag <= sabs;
      neg  <= field[0] ^ scale[31];
      acc  <= '0;
      cnt  <= '0;
    end else if (busy) begin
      acc <= {sum, acc[30:1]};
      mag <= mag >> 1;
      cnt <= cnt + 5'd1;
      if (cnt == 5'd30) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    if (prod == '0) result = '0;
    else if (neg) result = (prod >= 47'h8000_0000) ? 32'h8000_0000 : 32'h0 - prod[31:0];
    else result = (prod > 47'h7fff_ffff) ? 32'h7fff_ffff : prod[31:0];
  end
endmodule

// File: rtl/telemetry_bitfield_unpacker.sv
// telemetry bitfield unpacker top level
// channels: in (commands and packet bytes), out (pin, scaled value, last flag), cfg writes
// in transactions: func 0 edits a pin-sorted sensor table of up to 16 entries,
// func 1 delivers one packet byte; after the header each byte's bits shift
// one per cycle into a field buffer, and each completed field is scaled by a
// serial shift-add multiplier.
// steps: a flagged command is ignored and a clear command empties the table
// and the packet state; any other command searches the table entry by entry,
// and an insert then moves the later entries up one at a time; a packet byte
// is accepted, shifted in bit by bit and checked, and each field it completes
// is scaled in the multiplier and handed off once the receiver is ready.
// the last byte of a packet flushes every remaining sensor, padding its missing bits with zeros.
// results wait in an output register; while the receiver stalls the block
// holds and takes no new input. reset empties the table and the packet state,
// clear_code returns to 63, header_bytes to 8. no clearing pass.
// depends on tbu_pkg, tbu_if, tbu_scaler
module telemetry_bitfield_unpacker (
  input logic clk,
  input logic rst,
  tbu_in_if.sink   in_ch,
  tbu_out_if.source out_ch,
  tbu_cfg_if.sink  cfg
);
  import tbu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_SHIFT, S_SHIFTBYTE, S_CHECK, S_EMIT, S_MUL, S_OUT, S_DONE
  } state_t;

  state_t        state;
  entry_t        tbl [MaxSensors];
  logic [CntW-1:0] count;
  logic [7:0]    bpos;
  logic [39:0]   buffer;
  logic [BitW+2:0] held;
  logic [CntW-1:0] nxt;
  logic [5:0]    clr_code;
  logic [3:0]    hdr;
  in_item_t      cur;
  logic [CntW-1:0] ptr;
  logic [2:0]    bitn;
  logic [5:0]    wnorm;
  logic          flushing;
  logic          mstart;
  logic          mdone;
  logic [31:0]   mres;
  entry_t        ent;
  logic [31:0]   fmask;
  logic          take;

  assign cfg.ready = (state == S_IDLE);
  assign in_ch.ready = (state == S_IDLE) && !cfg.valid;
  assign ent = tbl[nxt[IdxW-1:0]];
  assign fmask = (ent.width == 6'd32) ? 32'hffff_ffff : ((32'h1 << ent.width) - 32'h1);
  assign take = (nxt < count) && (flushing || held >= {3'd0, ent.width});

  always_comb begin
    wnorm = cur.field_bits;
    if (wnorm == 6'd0) wnorm = 6'd1;
    if (wnorm > 6'(MaxFieldBits)) wnorm = 6'(MaxFieldBits);
  end

  tbu_scaler u_scaler (
    .clk, .rst, .start(mstart), .field(buffer[31:0] & fmask),
    .width(ent.width), .scale(ent.scale), .done(mdone), .result(mres)
  );

  always_ff @(posedge clk) begin
    mstart <= !rst && (state == S_CHECK) && take;
    if (rst) begin
      state <= S_IDLE;
      count <= '0; bpos <= '0; buffer <= '0; held <= '0; nxt <= '0;
      clr_code <= 6'd63; hdr <= 4'd8;
      out_ch.valid <= 1'b0;
      flushing <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg.valid) begin
            if (cfg.data.idx == 4'(RegClearCode)) clr_code <= cfg.data.data[5:0];
            else if (cfg.data.idx == 4'(RegHeaderBytes)) hdr <= cfg.data.data[3:0];
          end else if (in_ch.valid) begin
            cur <= in_ch.data;
            ptr <= '0;
            if (in_ch.data.func == FuncCommand) begin
              if ((in_ch.data.command_byte & (FlagWrite | FlagState)) != 8'd0) begin
                state <= S_IDLE;
              end else if ((in_ch.data.command_byte & TypeMask) == {2'b00, clr_code}) begin
                count <= '0;
                bpos <= '0; buffer <= '0; held <= '0; nxt <= '0;
              end else begin
                state <= S_SEARCH;
              end
            end else begin
              bitn <= '0;
              flushing <= 1'b0;
              if (bpos >= {4'd0, hdr} && nxt < count) state <= S_SHIFTBYTE;
              else state <= S_CHECK;
            end
          end
        end
        S_SEARCH: begin
          if (ptr < count && tbl[ptr[IdxW-1:0]].pin < cur.pin) begin
            ptr <= ptr + 1'b1;
          end else if (ptr < count && tbl[ptr[IdxW-1:0]].pin == cur.pin) begin
            tbl[ptr[IdxW-1:0]].width <= wnorm;
            tbl[ptr[IdxW-1:0]].scale <= cur.field_scale;
            bpos <= '0; buffer <= '0; held <= '0; nxt <= '0;
            state <= S_IDLE;
          end else if (count >= CntW'(MaxSensors)) begin
            state <= S_IDLE;
          end else begin
            ptr <= count;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // move one entry up per cycle, ptr walks down from count
          if (ptr > '0 && tbl[ptr[IdxW-1:0] - 1'b1].pin > cur.pin) begin
            tbl[ptr[IdxW-1:0]] <= tbl[ptr[IdxW-1:0] - 1'b1];
            ptr <= ptr - 1'b1;
          end else begin
            tbl[ptr[IdxW-1:0]] <= '{pin: cur.pin, width: wnorm, scale: cur.field_scale};
            count <= count + 1'b1;
            bpos <= '0; buffer <= '0; held <= '0; nxt <= '0;
            state <= S_IDLE;
          end
        end
        S_SHIFTBYTE: begin
          buffer[held[5:0]] <= cur.packet_byte[bitn];
          held <= held + 1'b1;
          cur.packet_byte <= cur.packet_byte;
          bitn <= bitn + 1'b1;
          if (bitn == 3'd7) state <= S_CHECK;
        end
        S_CHECK: begin
          if (take) begin
            state <= S_MUL;
          end else if (cur.last_byte && !flushing) begin
            flushing <= 1'b1;
          end else begin
            if (cur.last_byte) begin
              bpos <= '0; buffer <= '0; held <= '0; nxt <= '0;
            end else if (bpos != PosMax) begin
              bpos <= bpos + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          if (mdone) begin
            out_ch.data.out_pin <= ent.pin;
            out_ch.data.out_value <= mres;
            out_ch.data.last_of_run <= (nxt + 1'b1 == count);
            out_ch.valid <= 1'b1;
            buffer <= buffer >> ent.width;
            held <= (held >= {3'd0, ent.width}) ? held - {3'd0, ent.width} : '0;
            nxt <= nxt + 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/tbu_checker.sv
// port-level checks for the unpacker
// depends on the top level, attached to it by bind
module tbu_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [7:0] out_pin,
  input logic cfg_valid,
  input logic cfg_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pin)) else $error("out held");
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_cfg_first: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> !(in_valid && in_ready)) else $error("cfg and input together");
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("output after reset");
endmodule

bind telemetry_bitfield_unpacker tbu_checker u_tbu_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_pin(out_ch.data.out_pin),
  .cfg_valid(cfg.valid), .cfg_ready(cfg.ready)
);
